// ----- rtl/audio_frame_deframer_ring_writer_macros.svh -----
// Assertion macros used by the checker file of the deframer ring writer.
`ifndef AUDIO_FRAME_DEFRAMER_RING_WRITER_MACROS_SVH
`define AUDIO_FRAME_DEFRAMER_RING_WRITER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define AFDRW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("afdrw assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define AFDRW_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("afdrw assertion failed");

`endif

// ----- rtl/afdrw_pkg.sv -----
package afdrw_pkg;

  // Parameter defaults
  localparam int unsigned FramesPerReadDef = 256;
  localparam int unsigned RingDepthDef     = 4096;

  // Fixed widths
  localparam int unsigned SampleW  = 24;
  localparam int unsigned CountW   = 16;
  localparam int unsigned RevW     = 8;
  localparam int unsigned SlotW    = 12;
  localparam int unsigned CfgW     = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned WarmW    = 4;

  // Header checks and counters
  localparam int unsigned RevMin      = 30;
  localparam int unsigned RevMax      = 251;
  localparam int unsigned WarmupReads = 10;
  localparam int unsigned ElapsedMax  = 8191;

  // Register reset values
  localparam int unsigned RingFramesRst   = 2570;
  localparam int unsigned PeriodFramesRst = 257;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDownmix      = 2'd0,
    CfgRingFrames   = 2'd1,
    CfgPeriodFrames = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EvHdrOk    = 3'd0,
    EvBadRev   = 3'd1,
    EvCountBig = 3'd2,
    EvWritten  = 3'd3,
    EvDiscard  = 3'd4
  } event_e;

  typedef struct packed {
    logic            downmix_enable;
    logic [CfgW-1:0] ring_frames;
    logic [CfgW-1:0] period_frames;
  } cfg_t;

  typedef struct packed {
    event_e                     event_res;
    logic [SlotW-1:0]           ring_slot;
    logic signed [SampleW-1:0]  out_ch0;
    logic signed [SampleW-1:0]  out_ch1;
    logic signed [SampleW-1:0]  out_ch2;
    logic signed [SampleW-1:0]  out_ch3;
    logic                       period_done;
    logic                       overrun_report;
  } result_t;

endpackage

// ----- rtl/afdrw_cfg.sv -----
module afdrw_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [afdrw_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [afdrw_pkg::CfgW-1:0]        cfg_wdata_i,
  output afdrw_pkg::cfg_t                   cfg_o
);

  afdrw_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (afdrw_pkg::cfg_idx_e'(cfg_idx_i))
        afdrw_pkg::CfgDownmix:      cfg_d.downmix_enable = cfg_wdata_i[0];
        afdrw_pkg::CfgRingFrames:   cfg_d.ring_frames    = cfg_wdata_i;
        afdrw_pkg::CfgPeriodFrames: cfg_d.period_frames  = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.downmix_enable <= 1'b0;
      cfg_q.ring_frames    <= afdrw_pkg::CfgW'(afdrw_pkg::RingFramesRst);
      cfg_q.period_frames  <= afdrw_pkg::CfgW'(afdrw_pkg::PeriodFramesRst);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/afdrw_core.sv -----
module afdrw_core #(
  parameter int unsigned FRAMES_PER_READ = afdrw_pkg::FramesPerReadDef,
  parameter int unsigned RING_DEPTH      = afdrw_pkg::RingDepthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic                                   operation_i,
  input  logic [afdrw_pkg::CountW-1:0]           frame_count_i,
  input  logic [afdrw_pkg::RevW-1:0]             revision_i,
  input  logic                                   overrun_i,
  input  logic signed [afdrw_pkg::SampleW-1:0]   sample_ch0_i,
  input  logic signed [afdrw_pkg::SampleW-1:0]   sample_ch1_i,
  input  logic signed [afdrw_pkg::SampleW-1:0]   sample_ch2_i,
  input  logic signed [afdrw_pkg::SampleW-1:0]   sample_ch3_i,
  input  afdrw_pkg::cfg_t                        cfg_i,
  output afdrw_pkg::result_t                     res_o
);

  localparam int unsigned OffW  = $clog2(RING_DEPTH);
  localparam int unsigned RingW = (OffW + 1 > afdrw_pkg::CfgW) ? OffW + 1 : afdrw_pkg::CfgW;
  localparam int unsigned LeftW = $clog2(FRAMES_PER_READ + 1);
  localparam int unsigned SumW  = afdrw_pkg::SampleW + 1;
  localparam logic [RingW-1:0] RingDepthW = RingW'(RING_DEPTH);

  logic [OffW-1:0]            ring_offset_q, ring_offset_d;
  logic [afdrw_pkg::CfgW-1:0] elapsed_q, elapsed_d;
  logic [LeftW-1:0]           left_q, left_d;
  logic [afdrw_pkg::WarmW-1:0] warm_q, warm_d;

  logic                       rev_ok, count_ok, warm, keep, chk_req;
  logic [RingW-1:0]           ring_ext, ring_eff, off_ext, slot, slot_inc, next_off;
  logic [afdrw_pkg::CfgW-1:0] elapsed_inc;
  logic signed [SumW-1:0]     mix_sum, mix_adj;
  logic signed [afdrw_pkg::SampleW-1:0] mix;

  // Header checks
  assign rev_ok   = (revision_i >= afdrw_pkg::RevW'(afdrw_pkg::RevMin)) &&
                    (revision_i <= afdrw_pkg::RevW'(afdrw_pkg::RevMax));
  assign count_ok = frame_count_i <= afdrw_pkg::CountW'(FRAMES_PER_READ);
  assign warm     = warm_q >= afdrw_pkg::WarmW'(afdrw_pkg::WarmupReads);
  assign keep     = operation_i && (left_q != '0);

  // Clamp ring size, pick the slot and wrap the next offset
  assign ring_ext = RingW'(cfg_i.ring_frames);
  assign ring_eff = ((cfg_i.ring_frames == '0) || (ring_ext > RingDepthW)) ? RingDepthW
                                                                           : ring_ext;
  assign off_ext  = RingW'(ring_offset_q);
  assign slot     = (off_ext >= ring_eff) ? '0 : off_ext;
  assign slot_inc = slot + RingW'(1);
  assign next_off = (slot_inc >= ring_eff) ? '0 : slot_inc;

  // Saturating frame count since the last period
  assign elapsed_inc = (elapsed_q < afdrw_pkg::CfgW'(afdrw_pkg::ElapsedMax)) ?
                       elapsed_q + afdrw_pkg::CfgW'(1) : elapsed_q;

  // Average of channels 0 and 1, rounded toward zero
  assign mix_sum = SumW'(sample_ch0_i) + SumW'(sample_ch1_i);
  assign mix_adj = mix_sum + SumW'(mix_sum[SumW-1] & mix_sum[0]);
  assign mix     = mix_adj[SumW-1:1];

  always_comb begin
    res_o         = '0;
    res_o.event_res = afdrw_pkg::EvDiscard;
    ring_offset_d = ring_offset_q;
    elapsed_d     = elapsed_q;
    left_d        = left_q;
    warm_d        = warm ? warm_q : warm_q + afdrw_pkg::WarmW'(1);
    chk_req       = 1'b0;

    if (!operation_i) begin
      // Status header: start a new read
      left_d = '0;
      if (!rev_ok) begin
        res_o.event_res = afdrw_pkg::EvBadRev;
      end else begin
        res_o.overrun_report = overrun_i & warm;
        if (!count_ok) begin
          res_o.event_res = afdrw_pkg::EvCountBig;
        end else begin
          res_o.event_res = afdrw_pkg::EvHdrOk;
          left_d          = LeftW'(frame_count_i);
          chk_req         = (frame_count_i == '0);
        end
      end
    end else begin
      warm_d = warm_q;
      if (keep) begin
        // Kept audio frame: write to the ring
        res_o.event_res = afdrw_pkg::EvWritten;
        res_o.ring_slot = afdrw_pkg::SlotW'(slot);
        res_o.out_ch0   = cfg_i.downmix_enable ? mix : sample_ch0_i;
        res_o.out_ch1   = cfg_i.downmix_enable ? mix : sample_ch1_i;
        res_o.out_ch2   = sample_ch2_i;
        res_o.out_ch3   = sample_ch3_i;
        ring_offset_d   = OffW'(next_off);
        elapsed_d       = elapsed_inc;
        left_d          = left_q - LeftW'(1);
        chk_req         = (left_q == LeftW'(1));
      end
    end

    // Period check at the end of an accepted read
    if (chk_req && (elapsed_d >= cfg_i.period_frames)) begin
      res_o.period_done = 1'b1;
      elapsed_d         = elapsed_d - cfg_i.period_frames;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_offset_q <= '0;
      elapsed_q     <= '0;
      left_q        <= '0;
      warm_q        <= '0;
    end else if (accept_i) begin
      ring_offset_q <= ring_offset_d;
      elapsed_q     <= elapsed_d;
      left_q        <= left_d;
      warm_q        <= warm_d;
    end
  end

endmodule

// ----- rtl/afdrw_out_stage.sv -----
module afdrw_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                accept_o,
  input  afdrw_pkg::result_t  res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output afdrw_pkg::result_t  res_o
);

  logic               valid_q;
  afdrw_pkg::result_t res_q;

  // Take a new beat whenever the held result is empty or leaves this cycle
  assign in_ready_o = !valid_q || out_ready_i;
  assign accept_o   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Hold the result payload until it is taken
  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/audio_frame_deframer_ring_writer.sv -----
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | operation, frame_count, revision, overrun,
//         |           |                         | sample_ch0..sample_ch3
// out     | output    | out_valid_o/out_ready_i | event_res, ring_slot, out_ch0..out_ch3,
//         |           |                         | period_done, overrun_report
// cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One beat per cycle while in_ready_o is high; each result appears in the cycle after its input beat, from the
// single result register that follows the header/frame logic.
// Reset clears the ring offset, period count, frames left and warm-up count, and loads
// the register defaults (downmix off, ring 2570 frames, period 257 frames).
// in_ready_o is low only while a result is held and out_ready_i is low.
module audio_frame_deframer_ring_writer #(
  parameter int unsigned FRAMES_PER_READ = afdrw_pkg::FramesPerReadDef,
  parameter int unsigned RING_DEPTH      = afdrw_pkg::RingDepthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [afdrw_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [afdrw_pkg::CfgW-1:0]             cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   operation_i,
  input  logic [afdrw_pkg::CountW-1:0]           frame_count_i,
  input  logic [afdrw_pkg::RevW-1:0]             revision_i,
  input  logic                                   overrun_i,
  input  logic signed [afdrw_pkg::SampleW-1:0]   sample_ch0_i,
  input  logic signed [afdrw_pkg::SampleW-1:0]   sample_ch1_i,
  input  logic signed [afdrw_pkg::SampleW-1:0]   sample_ch2_i,
  input  logic signed [afdrw_pkg::SampleW-1:0]   sample_ch3_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [2:0]                             event_res_o,
  output logic [afdrw_pkg::SlotW-1:0]            ring_slot_o,
  output logic signed [afdrw_pkg::SampleW-1:0]   out_ch0_o,
  output logic signed [afdrw_pkg::SampleW-1:0]   out_ch1_o,
  output logic signed [afdrw_pkg::SampleW-1:0]   out_ch2_o,
  output logic signed [afdrw_pkg::SampleW-1:0]   out_ch3_o,
  output logic                                   period_done_o,
  output logic                                   overrun_report_o
);

  afdrw_pkg::cfg_t    cfg;
  afdrw_pkg::result_t res_next, res_out;
  logic               accept;

  afdrw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  afdrw_core #(
    .FRAMES_PER_READ (FRAMES_PER_READ),
    .RING_DEPTH      (RING_DEPTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .frame_count_i (frame_count_i),
    .revision_i    (revision_i),
    .overrun_i     (overrun_i),
    .sample_ch0_i  (sample_ch0_i),
    .sample_ch1_i  (sample_ch1_i),
    .sample_ch2_i  (sample_ch2_i),
    .sample_ch3_i  (sample_ch3_i),
    .cfg_i         (cfg),
    .res_o         (res_next)
  );

  afdrw_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .accept_o    (accept),
    .res_i       (res_next),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  // Unpack the held result onto the ports
  assign event_res_o      = res_out.event_res;
  assign ring_slot_o      = res_out.ring_slot;
  assign out_ch0_o        = res_out.out_ch0;
  assign out_ch1_o        = res_out.out_ch1;
  assign out_ch2_o        = res_out.out_ch2;
  assign out_ch3_o        = res_out.out_ch3;
  assign period_done_o    = res_out.period_done;
  assign overrun_report_o = res_out.overrun_report;

endmodule

// ----- rtl/afdrw_checker.sv -----
`include "audio_frame_deframer_ring_writer_macros.svh"

module afdrw_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic [2:0]                            event_res_o,
  input logic [afdrw_pkg::SlotW-1:0]           ring_slot_o,
  input logic signed [afdrw_pkg::SampleW-1:0]  out_ch0_o,
  input logic signed [afdrw_pkg::SampleW-1:0]  out_ch1_o,
  input logic signed [afdrw_pkg::SampleW-1:0]  out_ch2_o,
  input logic signed [afdrw_pkg::SampleW-1:0]  out_ch3_o,
  input logic                                  period_done_o,
  input logic                                  overrun_report_o
);

  logic not_written, no_period_code;

  assign not_written    = out_valid_o && (event_res_o != afdrw_pkg::EvWritten);
  assign no_period_code = out_valid_o && ((event_res_o == afdrw_pkg::EvBadRev) ||
                                          (event_res_o == afdrw_pkg::EvCountBig) ||
                                          (event_res_o == afdrw_pkg::EvDiscard));

  // A held result stays until taken
  `AFDRW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // Input back-pressure only while a result is stuck at the output
  `AFDRW_ASSERT_IMP(a_ready_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // Slot and samples are zero unless a frame was written
  `AFDRW_ASSERT_IMP(a_zero_payload, clk_i, rst_ni, not_written,
                    (ring_slot_o == '0) && (out_ch0_o == '0) && (out_ch1_o == '0) &&
                    (out_ch2_o == '0) && (out_ch3_o == '0))

  // Rejected headers and discarded frames never close a period
  `AFDRW_ASSERT_IMP(a_no_period, clk_i, rst_ni, no_period_code, !period_done_o)

  // A bad revision never reports an overrun
  `AFDRW_ASSERT_IMP(a_badrev_ovr, clk_i, rst_ni,
                    out_valid_o && (event_res_o == afdrw_pkg::EvBadRev), !overrun_report_o)

endmodule

bind audio_frame_deframer_ring_writer afdrw_checker u_afdrw_checker (.*);

// ----- dv/audio_frame_deframer_ring_writer_tb.sv -----
module audio_frame_deframer_ring_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseBeats = 180;
  localparam int unsigned NumPhases  = 8;

  // Beat kinds on the input channel
  localparam logic OpHeader = 1'b0;
  localparam logic OpFrame  = 1'b1;

  typedef struct {
    logic                                 op;
    logic [afdrw_pkg::CountW-1:0]         count;
    logic [afdrw_pkg::RevW-1:0]           rev;
    logic                                 ovr;
    logic signed [afdrw_pkg::SampleW-1:0] s0;
    logic signed [afdrw_pkg::SampleW-1:0] s1;
    logic signed [afdrw_pkg::SampleW-1:0] s2;
    logic signed [afdrw_pkg::SampleW-1:0] s3;
  } beat_t;

  // Tracks the deframer state and holds the results that are still due
  class frame_ring_scoreboard;
    logic                downmix;
    int unsigned         ring_size;
    int unsigned         period_len;
    int unsigned         next_slot;
    int unsigned         frames_since_period;
    int unsigned         frames_to_keep;
    int unsigned         headers_seen;
    afdrw_pkg::result_t  due_results[$];
    int unsigned         mismatches;

    function new();
      downmix             = 1'b0;
      ring_size           = afdrw_pkg::RingFramesRst;
      period_len          = afdrw_pkg::PeriodFramesRst;
      next_slot           = 0;
      frames_since_period = 0;
      frames_to_keep      = 0;
      headers_seen        = 0;
      mismatches          = 0;
    endfunction

    function void write_reg(afdrw_pkg::cfg_idx_e idx, logic [afdrw_pkg::CfgW-1:0] data);
      case (idx)
        afdrw_pkg::CfgDownmix:      downmix = data[0];
        afdrw_pkg::CfgRingFrames:   ring_size = 32'(data);
        afdrw_pkg::CfgPeriodFrames: period_len = 32'(data);
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Take one period off the count when it has been reached
    function bit period_hit();
      if (frames_since_period >= period_len) begin
        frames_since_period -= period_len;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_beat(beat_t b);
      afdrw_pkg::result_t r;
      bit                 warm;
      int                 c0;
      int                 c1;
      int                 mix;
      int unsigned        ring;
      int unsigned        slot;
      r = '0;
      r.event_res = afdrw_pkg::EvHdrOk;
      if (b.op == OpHeader) begin
        warm = headers_seen >= afdrw_pkg::WarmupReads;
        frames_to_keep = 0;
        if (b.rev < afdrw_pkg::RevMin || b.rev > afdrw_pkg::RevMax) begin
          r.event_res = afdrw_pkg::EvBadRev;
        end else begin
          r.overrun_report = b.ovr && warm;
          if (b.count > afdrw_pkg::FramesPerReadDef) begin
            r.event_res = afdrw_pkg::EvCountBig;
          end else begin
            frames_to_keep = 32'(b.count);
            // an empty read closes at its header
            if (b.count == 0) r.period_done = period_hit();
          end
        end
        if (headers_seen < afdrw_pkg::WarmupReads) headers_seen++;
      end else if (frames_to_keep == 0) begin
        r.event_res = afdrw_pkg::EvDiscard;
      end else begin
        c0 = int'(b.s0);
        c1 = int'(b.s1);
        if (downmix) begin
          mix = (c0 + c1) / 2;
          c0  = mix;
          c1  = mix;
        end
        ring = ring_size;
        if (ring == 0 || ring > afdrw_pkg::RingDepthDef) ring = afdrw_pkg::RingDepthDef;
        // a shrunken ring restarts at slot zero
        slot = (next_slot >= ring) ? 0 : next_slot;
        next_slot = (slot + 1 >= ring) ? 0 : slot + 1;
        if (frames_since_period < afdrw_pkg::ElapsedMax) frames_since_period++;
        frames_to_keep--;
        r.event_res = afdrw_pkg::EvWritten;
        r.ring_slot = slot[afdrw_pkg::SlotW-1:0];
        r.out_ch0   = c0[afdrw_pkg::SampleW-1:0];
        r.out_ch1   = c1[afdrw_pkg::SampleW-1:0];
        r.out_ch2   = b.s2;
        r.out_ch3   = b.s3;
        if (frames_to_keep == 0) r.period_done = period_hit();
      end
      due_results.push_back(r);
    endfunction

    task report_mismatch(string field, logic [31:0] got_v, logic [31:0] exp_v);
      $display("%0t: mismatch on %s, got %0h, expected %0h", $time, field, got_v, exp_v);
      mismatches++;
    endtask

    task check_result(afdrw_pkg::result_t got);
      afdrw_pkg::result_t exp;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.event_res), 32'd0);
      end else begin
        exp = due_results.pop_front();
        if (got.event_res !== exp.event_res)
          report_mismatch("event_res", 32'(got.event_res), 32'(exp.event_res));
        if (got.ring_slot !== exp.ring_slot)
          report_mismatch("ring_slot", 32'(got.ring_slot), 32'(exp.ring_slot));
        if (got.out_ch0 !== exp.out_ch0)
          report_mismatch("out_ch0", 32'(got.out_ch0), 32'(exp.out_ch0));
        if (got.out_ch1 !== exp.out_ch1)
          report_mismatch("out_ch1", 32'(got.out_ch1), 32'(exp.out_ch1));
        if (got.out_ch2 !== exp.out_ch2)
          report_mismatch("out_ch2", 32'(got.out_ch2), 32'(exp.out_ch2));
        if (got.out_ch3 !== exp.out_ch3)
          report_mismatch("out_ch3", 32'(got.out_ch3), 32'(exp.out_ch3));
        if (got.period_done !== exp.period_done)
          report_mismatch("period_done", 32'(got.period_done), 32'(exp.period_done));
        if (got.overrun_report !== exp.overrun_report)
          report_mismatch("overrun_report", 32'(got.overrun_report),
                          32'(exp.overrun_report));
      end
    endtask
  endclass

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [afdrw_pkg::CfgIdxW-1:0]        cfg_idx_i = '0;
  logic [afdrw_pkg::CfgW-1:0]           cfg_wdata_i = '0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_ready_o;
  logic                                 operation_i = 1'b0;
  logic [afdrw_pkg::CountW-1:0]         frame_count_i = '0;
  logic [afdrw_pkg::RevW-1:0]           revision_i = '0;
  logic                                 overrun_i = 1'b0;
  logic signed [afdrw_pkg::SampleW-1:0] sample_ch0_i = '0;
  logic signed [afdrw_pkg::SampleW-1:0] sample_ch1_i = '0;
  logic signed [afdrw_pkg::SampleW-1:0] sample_ch2_i = '0;
  logic signed [afdrw_pkg::SampleW-1:0] sample_ch3_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic [2:0]                           event_res_o;
  logic [afdrw_pkg::SlotW-1:0]          ring_slot_o;
  logic signed [afdrw_pkg::SampleW-1:0] out_ch0_o;
  logic signed [afdrw_pkg::SampleW-1:0] out_ch1_o;
  logic signed [afdrw_pkg::SampleW-1:0] out_ch2_o;
  logic signed [afdrw_pkg::SampleW-1:0] out_ch3_o;
  logic                                 period_done_o;
  logic                                 overrun_report_o;

  frame_ring_scoreboard sb;
  int unsigned          idle_pct = 0;
  int unsigned          stall_pct = 0;
  int unsigned          beats_sent = 0;
  int unsigned          beat_goal = 0;
  int unsigned          cycles = 0;
  beat_t                seen_beat;
  afdrw_pkg::result_t   seen_result;

  audio_frame_deframer_ring_writer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .frame_count_i   (frame_count_i),
    .revision_i      (revision_i),
    .overrun_i       (overrun_i),
    .sample_ch0_i    (sample_ch0_i),
    .sample_ch1_i    (sample_ch1_i),
    .sample_ch2_i    (sample_ch2_i),
    .sample_ch3_i    (sample_ch3_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_res_o     (event_res_o),
    .ring_slot_o     (ring_slot_o),
    .out_ch0_o       (out_ch0_o),
    .out_ch1_o       (out_ch1_o),
    .out_ch2_o       (out_ch2_o),
    .out_ch3_o       (out_ch3_o),
    .period_done_o   (period_done_o),
    .overrun_report_o(overrun_report_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Predict every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      seen_beat.op    = operation_i;
      seen_beat.count = frame_count_i;
      seen_beat.rev   = revision_i;
      seen_beat.ovr   = overrun_i;
      seen_beat.s0    = sample_ch0_i;
      seen_beat.s1    = sample_ch1_i;
      seen_beat.s2    = sample_ch2_i;
      seen_beat.s3    = sample_ch3_i;
      sb.note_beat(seen_beat);
    end
  end

  // Check every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result.event_res      = afdrw_pkg::event_e'(event_res_o);
      seen_result.ring_slot      = ring_slot_o;
      seen_result.out_ch0        = out_ch0_o;
      seen_result.out_ch1        = out_ch1_o;
      seen_result.out_ch2        = out_ch2_o;
      seen_result.out_ch3        = out_ch3_o;
      seen_result.period_done    = period_done_o;
      seen_result.overrun_report = overrun_report_o;
      sb.check_result(seen_result);
    end
  end

  // Bias samples towards the extremes of the 24-bit range
  function automatic logic signed [afdrw_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(5))
      0:       return 24'h800000;
      1:       return 24'h7fffff;
      2:       return 24'h000000;
      3:       return 24'hffffff;
      default: return afdrw_pkg::SampleW'($urandom);
    endcase
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b.op    = 1'($urandom_range(1));
    b.count = afdrw_pkg::CountW'($urandom);
    b.rev   = afdrw_pkg::RevW'($urandom);
    b.ovr   = 1'($urandom_range(1));
    b.s0    = pick_sample();
    b.s1    = pick_sample();
    b.s2    = pick_sample();
    b.s3    = pick_sample();
    return b;
  endfunction

  // Hold the beat on the channel until it is taken
  task automatic send_beat(beat_t b);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= b.op;
    frame_count_i <= b.count;
    revision_i    <= b.rev;
    overrun_i     <= b.ovr;
    sample_ch0_i  <= b.s0;
    sample_ch1_i  <= b.s1;
    sample_ch2_i  <= b.s2;
    sample_ch3_i  <= b.s3;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  task automatic send_header(int unsigned count, int unsigned rev, bit ovr);
    beat_t b;
    b       = random_beat();
    b.op    = OpHeader;
    b.count = count[afdrw_pkg::CountW-1:0];
    b.rev   = rev[afdrw_pkg::RevW-1:0];
    b.ovr   = ovr;
    send_beat(b);
  endtask

  task automatic send_frame(logic [afdrw_pkg::SampleW-1:0] s0,
                            logic [afdrw_pkg::SampleW-1:0] s1,
                            logic [afdrw_pkg::SampleW-1:0] s2,
                            logic [afdrw_pkg::SampleW-1:0] s3);
    beat_t b;
    b    = random_beat();
    b.op = OpFrame;
    b.s0 = s0;
    b.s1 = s1;
    b.s2 = s2;
    b.s3 = s3;
    send_beat(b);
  endtask

  // Hold off the sender until every result is back and the block is quiet
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(afdrw_pkg::cfg_idx_e idx, int unsigned data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data[afdrw_pkg::CfgW-1:0];
    @(posedge clk_i);
    sb.write_reg(idx, data[afdrw_pkg::CfgW-1:0]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    // frame before any header, then rejected reads with their stray frames
    send_frame(24'h123456, 24'h654321, 24'h0f0f0f, 24'hf0f0f0);
    send_header(2, afdrw_pkg::RevMin - 1, 1'b1);
    send_frame(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_header(0, afdrw_pkg::RevMax + 1, 1'b0);
    send_header(afdrw_pkg::FramesPerReadDef + 1, afdrw_pkg::RevMin, 1'b1);
    // empty read closes its period check at the header
    send_header(0, afdrw_pkg::RevMax, 1'b0);
    send_header(16'hffff, 128, 1'b0);
    // short read with extreme samples and one frame past its count
    send_header(3, afdrw_pkg::RevMin, 1'b1);
    send_frame(24'h800000, 24'h800000, 24'h800000, 24'h800000);
    send_frame(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_frame(24'h800000, 24'h7fffff, 24'h000000, 24'hffffff);
    send_frame(24'h000001, 24'hffffff, 24'h555555, 24'haaaaaa);
    send_header(0, 0, 1'b1);
    send_header(16'h00ff, 255, 1'b1);
    // read cut short by the next header
    send_header(2, 40, 1'b0);
    send_frame(24'hffffff, 24'h000001, 24'h800001, 24'h7ffffe);
    send_header(1, 50, 1'b0);
    send_frame(24'h400000, 24'hc00000, 24'h000000, 24'hffffff);
    // warm-up is over: overrun is reported unless the revision is bad
    send_header(afdrw_pkg::FramesPerReadDef, afdrw_pkg::RevMin, 1'b1);
    send_header(0, 20, 1'b1);
    send_header(300, 100, 1'b1);
    send_header(0, afdrw_pkg::RevMax, 1'b0);
  endtask

  // Mostly well-formed reads, some cut short or overlong, some bad headers
  task automatic send_random_read();
    int unsigned pick;
    int unsigned count;
    int unsigned frames;
    int unsigned rev;
    pick = $urandom_range(99);
    if (pick < 70) count = $urandom_range(8);
    else if (pick < 92) count = $urandom_range(64, 9);
    else if (pick < 97) count = $urandom_range(afdrw_pkg::FramesPerReadDef, 65);
    else count = $urandom_range(65535, afdrw_pkg::FramesPerReadDef + 1);
    if ($urandom_range(99) < 88) rev = $urandom_range(afdrw_pkg::RevMax, afdrw_pkg::RevMin);
    else if ($urandom_range(1)) rev = $urandom_range(afdrw_pkg::RevMin - 1, 0);
    else rev = $urandom_range(255, afdrw_pkg::RevMax + 1);
    send_header(count, rev, 1'($urandom_range(1)));
    if (rev >= afdrw_pkg::RevMin && rev <= afdrw_pkg::RevMax &&
        count <= afdrw_pkg::FramesPerReadDef) begin
      frames = count;
      pick = $urandom_range(99);
      if (pick < 8) frames = $urandom_range(count);
      else if (pick < 14) frames = count + $urandom_range(3, 1);
    end else begin
      frames = $urandom_range(3);
    end
    // stop early once the beat budget is spent; the next header cuts the read
    for (int unsigned i = 0; i < frames && beats_sent < beat_goal; i++)
      send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endtask

  task automatic send_random_step();
    int unsigned pick;
    beat_t       b;
    pick = $urandom_range(99);
    if (pick < 85) begin
      send_random_read();
    end else if (pick < 93) begin
      send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    end else begin
      b    = random_beat();
      b.op = OpHeader;
      send_beat(b);
    end
  endtask

  // Load the registers and the idling mode for one phase
  task automatic apply_setting(int unsigned phase);
    int unsigned dm;
    int unsigned rf;
    int unsigned pf;
    case (phase)
      0: begin dm = 1; rf = 4096; pf = 1; end
      1: begin dm = 0; rf = 1; pf = 4096; end
      2: begin dm = 1; rf = 7; pf = 5; end
      3: begin dm = 0; rf = 0; pf = 0; end
      4: begin dm = 1; rf = 8191; pf = 8191; end
      5: begin dm = 0; rf = 3; pf = 2; end
      6: begin dm = $urandom_range(1); rf = $urandom_range(4096, 1); pf = $urandom_range(64, 1); end
      default: begin
        dm = $urandom_range(1);
        rf = $urandom_range(8191);
        pf = $urandom_range(300);
      end
    endcase
    write_reg(afdrw_pkg::CfgDownmix, dm);
    write_reg(afdrw_pkg::CfgRingFrames, rf);
    write_reg(afdrw_pkg::CfgPeriodFrames, pf);
    case (phase % 4)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 61; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 61; end
      default: begin idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      apply_setting(phase);
      beats_sent = 0;
      beat_goal  = PhaseBeats / 2;
      while (beats_sent < beat_goal) send_random_step();
      // let the block run dry mid-phase
      drain_results();
      beat_goal = PhaseBeats;
      while (beats_sent < beat_goal) send_random_step();
    end
    drain_results();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
